// ----- sv/arq_rt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_rt_pkg
// Types and codes shared by the retransmit tracker and its table cells.
// ----------------------------------------------------------------------------
package arq_rt_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_NAK     = 2'd2;
    localparam logic [1:0] ACT_TICK    = 2'd3;

    localparam logic [3:0] EV_FIRST     = 4'd0;
    localparam logic [3:0] EV_RESEND    = 4'd1;
    localparam logic [3:0] EV_ACKED     = 4'd2;
    localparam logic [3:0] EV_NAKED     = 4'd3;
    localparam logic [3:0] EV_TIMEOUT   = 4'd4;
    localparam logic [3:0] EV_SENDERR   = 4'd5;
    localparam logic [3:0] EV_STRAY_ACK = 4'd6;
    localparam logic [3:0] EV_STRAY_NAK = 4'd7;
    localparam logic [3:0] EV_FULL      = 4'd8;

    localparam logic [7:0] SEQ_MAX = 8'hFF;
    localparam logic [7:0] ATT_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [7:0]  seq;
        logic [7:0]  peer_status;
        logic [7:0]  max_attempts;
        logic [31:0] retry_interval;
        logic        send_ok;
    } req_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] out_seq;
        logic [7:0] out_status;
        logic       last;
    } evt_t;

    typedef struct packed {
        logic [7:0]  seq;
        logic [7:0]  attempts;
        logic [31:0] sent_at;
        logic [7:0]  limit;
        logic [31:0] interval;
    } entry_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic bump;
    } cell_ctrl_t;

endpackage

// ----- sv/arq_retransmit_tracker.sv -----
`timescale 1ns / 1ps
// Enqueue skips sequence numbers in use in S_SEQ; ack/nak pass through S_ACK;
// tick walks the table in S_TICK, results leave as they are found; all end in S_FLUSH.
// Throughput: one beat at a time; table walk one entry per cycle, unless stalled.
// Reset: table empty, next sequence number 1, output register empty.
// ----------------------------------------------------------------------------
// arq_retransmit_tracker
// Ordered table of frames awaiting acknowledgement, built as a chain of cells.
// ----------------------------------------------------------------------------
module arq_retransmit_tracker
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  arq_rt_pkg::req_t  req,
    output logic              evt_valid,
    input  logic              evt_stall,
    output arq_rt_pkg::evt_t  evt
);
    import arq_rt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SEQ   = 5'b00010,
        S_ACK   = 5'b00100,
        S_TICK  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        nseq_reg, nseq_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [RES_W-1:0]  nres_reg, nres_next;
    evt_t              pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    evt_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    entry_t            cell_q [TABLE_DEPTH];
    cell_ctrl_t        ctrl   [TABLE_DEPTH];
    entry_t            new_entry;

    logic              can_push;
    logic              push_en;
    evt_t              push_data;
    logic              in_use;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              load_en;
    logic [IDX_W-1:0]  load_idx;
    logic              shift_en;
    logic [IDX_W-1:0]  rm_idx;
    logic              bump_en;
    entry_t            cur_e;
    logic [31:0]       elapsed;
    logic              expired;
    logic              left;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            if (g < TABLE_DEPTH - 1)
            begin : g_mid
                arq_rt_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl[g]),
                    .new_entry (new_entry),
                    .nbr       (cell_q[g + 1]),
                    .entry     (cell_q[g])
                );
            end
            else
            begin : g_end
                arq_rt_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl[g]),
                    .new_entry (new_entry),
                    .nbr       (cell_q[g]),
                    .entry     (cell_q[g])
                );
            end
        end
    endgenerate

    assign can_push = !out_valid_reg || !evt_stall;

    always_comb
    begin
        in_use  = 1'b0;
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            if (CNT_W'(j) < count_reg)
            begin
                if (cell_q[j].seq == nseq_reg)
                begin
                    in_use = 1'b1;
                end
                if (!hit && cell_q[j].seq == item_reg.seq)
                begin
                    hit     = 1'b1;
                    hit_idx = IDX_W'(j);
                end
            end
        end
    end

    assign cur_e   = cell_q[cur_reg[IDX_W-1:0]];
    assign elapsed = item_reg.now_ms - cur_e.sent_at;
    assign expired = elapsed >= cur_e.interval;
    assign left    = (cur_e.limit == 8'd0) || (cur_e.attempts < cur_e.limit);

    always_comb
    begin
        new_entry.seq      = nseq_reg;
        new_entry.attempts = 8'd1;
        new_entry.sent_at  = item_reg.now_ms;
        new_entry.limit    = item_reg.max_attempts;
        new_entry.interval = item_reg.retry_interval;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        nseq_next       = nseq_reg;
        cur_next        = cur_reg;
        nres_next       = nres_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push_en         = 1'b0;
        push_data       = pend_reg;
        load_en         = 1'b0;
        load_idx        = count_reg[IDX_W-1:0];
        shift_en        = 1'b0;
        rm_idx          = hit_idx;
        bump_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next       = req;
                    cur_next        = '0;
                    nres_next       = '0;
                    pend_valid_next = 1'b0;
                    priority if (req.action == ACT_ENQUEUE)
                    begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            pend_next       = '{EV_FULL, 8'd0, 8'd0, 1'b0};
                            pend_valid_next = 1'b1;
                            state_next      = S_FLUSH;
                        end
                        else
                        begin
                            state_next = S_SEQ;
                        end
                    end
                    else if (req.action == ACT_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        state_next = S_ACK;
                    end
                end
            end
            S_SEQ:
            begin
                nseq_next = (nseq_reg == SEQ_MAX) ? 8'd1 : nseq_reg + 8'd1;
                if (!in_use)
                begin
                    load_en         = 1'b1;
                    pend_valid_next = 1'b1;
                    state_next      = S_FLUSH;
                    if (item_reg.send_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                        pend_next  = '{EV_FIRST, nseq_reg, 8'd0, 1'b0};
                    end
                    else
                    begin
                        pend_next = '{EV_SENDERR, nseq_reg, 8'd0, 1'b0};
                    end
                end
            end
            S_ACK:
            begin
                pend_valid_next = 1'b1;
                state_next      = S_FLUSH;
                if (hit)
                begin
                    shift_en   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    pend_next  = '{(item_reg.action == ACT_ACK) ? EV_ACKED : EV_NAKED,
                                   item_reg.seq, item_reg.peer_status, 1'b0};
                end
                else
                begin
                    pend_next = '{(item_reg.action == ACT_ACK) ? EV_STRAY_ACK : EV_STRAY_NAK,
                                  item_reg.seq, item_reg.peer_status, 1'b0};
                end
            end
            S_TICK:
            begin
                rm_idx = cur_reg[IDX_W-1:0];
                if (cur_reg >= count_reg || nres_reg == RES_W'(MAX_RESULTS))
                begin
                    state_next = S_FLUSH;
                end
                else if (!expired)
                begin
                    cur_next = cur_reg + CNT_W'(1);
                end
                else if (!pend_valid_reg || can_push)
                begin
                    push_en         = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    nres_next       = nres_reg + RES_W'(1);
                    if (left && item_reg.send_ok)
                    begin
                        bump_en   = 1'b1;
                        cur_next  = cur_reg + CNT_W'(1);
                        pend_next = '{EV_RESEND, cur_e.seq, 8'd0, 1'b0};
                    end
                    else
                    begin
                        shift_en   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                        pend_next  = '{left ? EV_SENDERR : EV_TIMEOUT, cur_e.seq, 8'd0, 1'b0};
                    end
                end
            end
            S_FLUSH:
            begin
                push_data.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    push_en         = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            ctrl[j].load  = load_en && (IDX_W'(j) == load_idx);
            ctrl[j].shift = shift_en && (IDX_W'(j) >= rm_idx) && (j < TABLE_DEPTH - 1);
            ctrl[j].bump  = bump_en && (IDX_W'(j) == cur_reg[IDX_W-1:0]);
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push_en)
        begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
        else if (!evt_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            nseq_reg       <= 8'd1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_reg        <= '0;
            nres_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            nseq_reg       <= nseq_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cur_reg        <= cur_next;
            nres_reg       <= nres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

endmodule

// ----- sv/arq_rt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arq_rt_cell
// One table slot: load a new entry, take the neighbor's entry on removal,
// or restamp and count a resend.
// ----------------------------------------------------------------------------
module arq_rt_cell
(
    input  logic                   clk,
    input  arq_rt_pkg::cell_ctrl_t ctrl,
    input  arq_rt_pkg::entry_t     new_entry,
    input  arq_rt_pkg::entry_t     nbr,
    output arq_rt_pkg::entry_t     entry
);
    import arq_rt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.load)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr;
        end
        else if (ctrl.bump)
        begin
            entry_next.sent_at = new_entry.sent_at;
            if (entry_reg.attempts != ATT_MAX)
            begin
                entry_next.attempts = entry_reg.attempts + 8'd1;
            end
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the retransmit tracker against a behavioral table model: directed
// enqueue, ack, nak and tick rows, then random traffic with random idling and
// backpressure, comparing every event beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import arq_rt_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WATCHDOG   = 20000;
    localparam int N_RANDOM   = 250;
    localparam int N_DIRECTED = 12;

    typedef struct {
        req_t r;
        bit   typed;
        evt_t e;
    } row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic evt_valid;
    logic evt_stall;
    evt_t evt;

    entry_t tbl[DEPTH];
    int     tbl_count;
    logic [7:0] seq_next;
    evt_t   pending_events[$];
    evt_t   last_pred;
    int     errors;
    int     accepted;
    int     results_seen;
    int     idle_cycles;
    bit     timed_out;
    bit     hold_recv;
    bit     no_idle;
    bit     recv_burst_req;
    bit     done_stim;
    row_t   rows[N_DIRECTED];

    arq_retransmit_tracker #(.TABLE_DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic evt_t mk_evt(logic [3:0] ev, logic [7:0] s, logic [7:0] st);
        evt_t e;
        e.event_res  = ev;
        e.out_seq    = s;
        e.out_status = st;
        e.last       = 1'b0;
        return e;
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < tbl_count; i++)
            tbl[i] = tbl[i + 1];
        tbl_count--;
    endfunction

    function automatic logic [7:0] claim_seq();
        logic [7:0] cand;
        bit busy;
        for (int t = 0; t < 255; t++)
        begin
            cand = seq_next;
            seq_next = (seq_next == SEQ_MAX) ? 8'd1 : seq_next + 8'd1;
            busy = (cand == 8'd0);
            for (int i = 0; i < tbl_count; i++)
                if (tbl[i].seq == cand)
                    busy = 1'b1;
            if (!busy)
                return cand;
        end
        return 8'd1;
    endfunction

    function automatic void predict_events(req_t r);
        evt_t q[$];
        logic [31:0] elapsed;
        logic [7:0] s;
        bit left;
        bit hit;
        int i;
        case (r.action)
            ACT_ENQUEUE:
            begin
                if (tbl_count >= DEPTH)
                    q = {q, mk_evt(EV_FULL, 8'd0, 8'd0)};
                else
                begin
                    s = claim_seq();
                    if (r.send_ok)
                    begin
                        tbl[tbl_count].seq      = s;
                        tbl[tbl_count].attempts = 8'd1;
                        tbl[tbl_count].sent_at  = r.now_ms;
                        tbl[tbl_count].limit    = r.max_attempts;
                        tbl[tbl_count].interval = r.retry_interval;
                        tbl_count++;
                        q = {q, mk_evt(EV_FIRST, s, 8'd0)};
                    end
                    else
                        q = {q, mk_evt(EV_SENDERR, s, 8'd0)};
                end
            end
            ACT_ACK, ACT_NAK:
            begin
                hit = 1'b0;
                for (i = 0; i < tbl_count; i++)
                    if (tbl[i].seq == r.seq)
                    begin
                        drop_entry(i);
                        hit = 1'b1;
                        break;
                    end
                if (r.action == ACT_ACK)
                    q = {q, mk_evt(hit ? EV_ACKED : EV_STRAY_ACK, r.seq, r.peer_status)};
                else
                    q = {q, mk_evt(hit ? EV_NAKED : EV_STRAY_NAK, r.seq, r.peer_status)};
            end
            default:
            begin
                i = 0;
                while (i < tbl_count && q.size() < MAX_RESULTS)
                begin
                    elapsed = r.now_ms - tbl[i].sent_at;
                    left = (tbl[i].limit == 8'd0) || (tbl[i].attempts < tbl[i].limit);
                    s = tbl[i].seq;
                    if (elapsed >= tbl[i].interval)
                    begin
                        if (left && r.send_ok)
                        begin
                            tbl[i].sent_at = r.now_ms;
                            if (tbl[i].attempts != ATT_MAX)
                                tbl[i].attempts++;
                            q = {q, mk_evt(EV_RESEND, s, 8'd0)};
                            i++;
                        end
                        else
                        begin
                            drop_entry(i);
                            q = {q, mk_evt(left ? EV_SENDERR : EV_TIMEOUT, s, 8'd0)};
                        end
                    end
                    else
                        i++;
                end
            end
        endcase
        if (q.size() > 0)
        begin
            q[q.size() - 1].last = 1'b1;
            last_pred = q[q.size() - 1];
        end
        pending_events = {pending_events, q};
    endfunction

    function automatic req_t mk_req(logic [1:0] a, logic [31:0] now, logic [7:0] s,
                                    logic [7:0] st, logic [7:0] lim, logic [31:0] ivl,
                                    logic ok);
        req_t r;
        r.action         = a;
        r.now_ms         = now;
        r.seq            = s;
        r.peer_status    = st;
        r.max_attempts   = lim;
        r.retry_interval = ivl;
        r.send_ok        = ok;
        return r;
    endfunction

    function automatic req_t rand_req(logic [31:0] now);
        req_t r;
        int pick;
        logic [7:0] s;
        pick = $urandom_range(0, 99);
        s = (tbl_count > 0 && $urandom_range(0, 3) != 0) ?
            tbl[$urandom_range(0, tbl_count - 1)].seq : 8'($urandom);
        r = mk_req(ACT_TICK, now, s, 8'($urandom), 8'($urandom_range(0, 4)),
                   32'($urandom_range(0, 60)), ($urandom_range(0, 9) != 0));
        if ($urandom_range(0, 9) == 0)
            r.max_attempts = 8'($urandom);
        if ($urandom_range(0, 19) == 0)
            r.retry_interval = $urandom;
        if (pick < 40)
            r.action = ACT_ENQUEUE;
        else if (pick < 60)
            r.action = ACT_ACK;
        else if (pick < 70)
            r.action = ACT_NAK;
        return r;
    endfunction

    task automatic send_beat(req_t r);
        bit pause;
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_events(r);
        accepted++;
        @(negedge clk);
        pause = !no_idle && ($urandom_range(0, 99) < 8);
        if (pause)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < 8);
        end
    endtask

    // results
    always @(posedge clk)
    begin
        if (rst_n && evt_valid && !evt_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event expected none actual %p", $time, evt);
                errors++;
            end
            else
            begin
                if (evt !== pending_events[0])
                begin
                    $display("%0t: event mismatch expected %p actual %p",
                             $time, pending_events[0], evt);
                    errors++;
                end
                void'(pending_events.pop_front());
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (!rst_n)
            evt_stall <= 1'b0;
        else if (hold_recv)
            evt_stall <= 1'b1;
        else if (no_idle)
            evt_stall <= 1'b0;
        else
            evt_stall <= ($urandom_range(0, 99) < 8);
    end

    initial
    begin
        hold_recv = 1'b0;
        wait (recv_burst_req);
        @(negedge clk);
        hold_recv = 1'b1;
        repeat (150) @(negedge clk);
        hold_recv = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (evt_valid && !evt_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        // after reset; extremes; stray cases typed in
        rows[0]  = '{mk_req(ACT_ACK, 0, 8'hFF, 8'hFF, 0, 0, 1), 1,
                     mk_evt(EV_STRAY_ACK, 8'hFF, 8'hFF)};
        rows[1]  = '{mk_req(ACT_NAK, 0, 8'h00, 8'h00, 0, 0, 1), 1,
                     mk_evt(EV_STRAY_NAK, 8'h00, 8'h00)};
        rows[2]  = '{mk_req(ACT_TICK, 32'hFFFFFFFF, 0, 0, 0, 0, 1), 0, '0};
        rows[3]  = '{mk_req(ACT_ENQUEUE, 100, 0, 0, 8'd2, 32'd10, 1), 1,
                     mk_evt(EV_FIRST, 8'd1, 0)};
        rows[4]  = '{mk_req(ACT_ENQUEUE, 100, 0, 0, 8'd0, 32'hFFFFFFFF, 0), 1,
                     mk_evt(EV_SENDERR, 8'd2, 0)};
        rows[5]  = '{mk_req(ACT_ENQUEUE, 32'hFFFFFFF0, 0, 0, 8'hFF, 32'd0, 1), 0, '0};
        rows[6]  = '{mk_req(ACT_TICK, 32'd5, 0, 0, 0, 0, 1), 0, '0};
        rows[7]  = '{mk_req(ACT_TICK, 32'd200, 0, 0, 0, 0, 1), 0, '0};
        rows[8]  = '{mk_req(ACT_TICK, 32'd400, 0, 0, 0, 0, 0), 0, '0};
        rows[9]  = '{mk_req(ACT_ENQUEUE, 32'd0, 0, 0, 8'd1, 32'd0, 1), 0, '0};
        rows[10] = '{mk_req(ACT_NAK, 0, 8'd4, 8'hA5, 0, 0, 1), 0, '0};
        rows[11] = '{mk_req(ACT_TICK, 32'd1, 0, 0, 0, 0, 1), 0, '0};

        errors = 0;
        accepted = 0;
        results_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        no_idle = 1'b0;
        recv_burst_req = 1'b0;
        done_stim = 1'b0;
        tbl_count = 0;
        seq_next = 8'd1;
        last_pred = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                evt_t e;
                e = rows[i].e;
                e.last = 1'b1;
                send_beat(rows[i].r);
                if (last_pred !== e)
                begin
                    $display("%0t: row %0d expected %p actual model %p", $time, i, e,
                             last_pred);
                    errors++;
                end
            end
            else
                send_beat(rows[i].r);
        end

        // fill the table past full, then time all out at saturation
        for (int i = 0; i < DEPTH + 2; i++)
            send_beat(mk_req(ACT_ENQUEUE, 32'd1000, 0, 0, 8'd1, 32'd0, 1));
        send_beat(mk_req(ACT_TICK, 32'd1000, 0, 0, 0, 0, 1));
        // pause until drained
        req_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);

        recv_burst_req = 1'b1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            no_idle = (n >= 100 && n < 150);
            send_beat(rand_req(32'(n * 7 + $urandom_range(0, 6))));
        end
        req_valid <= 1'b0;
        no_idle = 1'b0;
        done_stim = 1'b1;

        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("run covered %0d request beats and %0d event beats", accepted, results_seen);
        $display("including table full, timeouts, send errors and stray acks/naks");
        if (errors == 0 && pending_events.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- arq_retransmit_tracker.f -----
sv/arq_rt_pkg.sv
sv/arq_rt_cell.sv
sv/arq_retransmit_tracker.sv
dv/tb_top.sv
